FILE: rtl/htw_pkg.sv
// Shared types and constants of the hashed timer wheel.
package htw_pkg;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_REFRESH = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // Ceiling dividend is timeout + tick length - 1, one bit wider than the timeout.
    localparam int unsigned DIVIDEND_W = 33;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned STEP_CNT_W = $clog2(DIVIDEND_W + 1);

    localparam logic [TICK_W-1:0] TICK_MS_RESET = 16'd10;

    // APB register map: register index sits in paddr[2].
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [0:0]  REG_TICK_MS = 1'b0;

endpackage

FILE: rtl/htw_div.sv
// Bit-serial divider that returns the quotient reduced modulo the slot count.
module htw_div
    import htw_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 256,
    parameter int unsigned SLOT_W    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [TICK_W-1:0]     divisor,
    output logic                  done,
    output logic [SLOT_W-1:0]     quot_mod
);

    localparam logic [SLOT_W:0] SLOTS_EXT = (SLOT_W + 1)'(NUM_SLOTS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [TICK_W-1:0]     rem_reg;
    logic [SLOT_W-1:0]     qmod_reg;

    logic [TICK_W:0]       trial;
    logic                  qbit;
    logic [TICK_W-1:0]     rem_next;
    logic [SLOT_W:0]       qm_trial;
    logic [SLOT_W-1:0]     qmod_next;

    // One restoring step; the quotient bit also folds into a running residue mod slots.
    always_comb begin
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        qbit      = (trial >= {1'b0, divisor});
        rem_next  = qbit ? TICK_W'(trial - {1'b0, divisor}) : trial[TICK_W-1:0];
        qm_trial  = {qmod_reg, qbit};
        qmod_next = (qm_trial >= SLOTS_EXT) ? SLOT_W'(qm_trial - SLOTS_EXT)
                                            : qm_trial[SLOT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == STEP_CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg  <= dividend;
            rem_reg  <= '0;
            qmod_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg  <= {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            qmod_reg <= qmod_next;
        end
    end

    assign done     = done_reg;
    assign quot_mod = qmod_reg;

endmodule

FILE: rtl/hashed_timer_wheel.sv
// Single-level hashed timing wheel over a fixed set of connection ids.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------------
//  s_*       | in        | s_tvalid/s_tready  | tuser: operation; tdata: conn_id, timeout
//  m_*       | out       | m_tvalid/m_tready  | tuser: expired_valid; tdata: id, count
//  APB       | in        | psel/penable       | tick_ms at address 0
//
//  Remove, or add/refresh that changes nothing: accept, then result.
//  Add and refresh: accept, the 33-step serial divider, divider done, arm and result.
//  Tick: scanning the slot memory one entry a cycle, then walking the hit mask,
//  one expiry per set bit, each waiting while the result register is stalled.
//  Reset is synchronous; no clearing pass (armed bits are flip-flops).
//  A stalled m_tready holds the result register; the sequencer waits on it.
module hashed_timer_wheel
    import htw_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 256,
    parameter int unsigned MAX_IDS   = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // [5:0] conn_id, [37:6] timeout, [39:38] zero
    input  logic [1:0]            s_tuser,   // [1:0] operation

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [5:0] expired_id, [12:6] live_count, [15:13] zero
    output logic                  m_tlast,
    output logic [0:0]            m_tuser,   // [0] expired_valid

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
    localparam int unsigned ID_W   = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int unsigned IDX_W  = $clog2(MAX_IDS + 1);
    localparam int unsigned CNT_W  = $clog2(MAX_IDS + 1);

    localparam logic [SLOT_W:0]  SLOTS_EXT = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [ID_W-1:0]  ID_TOP    = ID_W'(MAX_IDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ARM,
        ST_SCAN,
        ST_EMIT,
        ST_RESP
    } state_t;

    // Registers
    state_t              state_reg,    state_next;
    logic [TICK_W-1:0]   tick_ms_reg,  tick_ms_next;
    logic [SLOT_W-1:0]   cur_reg,      cur_next;
    logic [MAX_IDS-1:0]  armed_reg,    armed_next;
    logic [CNT_W-1:0]    total_reg,    total_next;
    logic [ID_W-1:0]     id_reg,       id_next;
    logic                zero_reg,     zero_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                cmp_vld_reg,  cmp_vld_next;
    logic [ID_W-1:0]     cmp_id_reg,   cmp_id_next;
    logic [MAX_IDS-1:0]  hit_mask_reg, hit_mask_next;
    logic [CNT_W-1:0]    hit_cnt_reg,  hit_cnt_next;
    logic [ID_W-1:0]     emit_idx_reg, emit_idx_next;
    logic                m_valid_reg,  m_valid_next;
    logic                m_exp_reg,    m_exp_next;
    logic [5:0]          m_id_reg,     m_id_next;
    logic                m_last_reg,   m_last_next;
    logic [6:0]          m_live_reg,   m_live_next;

    // Slot memory
    logic [SLOT_W-1:0]   slot_mem [MAX_IDS];
    logic [SLOT_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [SLOT_W-1:0]   target;

    // Divider
    logic                div_start;
    logic                div_done;
    logic [SLOT_W-1:0]   div_qmod;
    logic [TICK_W-1:0]   tick_len;
    logic [DIVIDEND_W-1:0] dividend;

    // Decode
    logic                s_acc;
    op_t                 s_op;
    logic [5:0]          s_conn_id;
    logic [31:0]         s_timeout;
    logic                id_ok;
    logic [ID_W-1:0]     id_idx;
    logic                out_free;
    logic                cfg_wr;
    logic                scan_hit;
    logic [SLOT_W-1:0]   step;
    logic [SLOT_W:0]     slot_sum;

    assign s_acc     = s_tvalid && s_tready;
    assign s_op      = op_t'(s_tuser);
    assign s_conn_id = s_tdata[5:0];
    assign s_timeout = s_tdata[37:6];
    assign id_ok     = ({1'b0, s_conn_id} < 7'(MAX_IDS));
    assign id_idx    = s_conn_id[ID_W-1:0];
    assign out_free  = !m_valid_reg || m_tready;

    // Zero tick length behaves as one.
    assign tick_len  = (tick_ms_reg == '0) ? TICK_W'(1) : tick_ms_reg;
    assign dividend  = {1'b0, s_timeout} + DIVIDEND_W'(tick_len) - DIVIDEND_W'(1);

    assign cfg_wr    = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_TICK_MS);
    assign pready    = 1'b1;
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_TICK_MS) ? {16'd0, tick_ms_reg} : '0;

    // Target slot: current plus the tick count mod slots, one ahead for a zero delay.
    assign step      = zero_reg ? SLOT_W'(1) : div_qmod;
    assign slot_sum  = {1'b0, cur_reg} + {1'b0, step};
    assign target    = (slot_sum >= SLOTS_EXT) ? SLOT_W'(slot_sum - SLOTS_EXT)
                                               : slot_sum[SLOT_W-1:0];

    assign scan_hit  = cmp_vld_reg && armed_reg[cmp_id_reg] && (rd_data_reg == cur_reg);
    assign mem_we    = (state_reg == ST_ARM);
    assign mem_re    = (state_reg == ST_SCAN) && (scan_idx_reg < IDX_W'(MAX_IDS));

    htw_div #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (tick_len),
        .done     (div_done),
        .quot_mod (div_qmod)
    );

    always_comb begin
        state_next    = state_reg;
        tick_ms_next  = cfg_wr ? pwdata[TICK_W-1:0] : tick_ms_reg;
        cur_next      = cur_reg;
        armed_next    = armed_reg;
        total_next    = total_reg;
        id_next       = id_reg;
        zero_next     = zero_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_id_next   = cmp_id_reg;
        hit_mask_next = hit_mask_reg;
        hit_cnt_next  = hit_cnt_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_exp_next    = m_exp_reg;
        m_id_next     = m_id_reg;
        m_last_next   = m_last_reg;
        m_live_next   = m_live_reg;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_op == OP_TICK) begin
                        cur_next      = (cur_reg == SLOT_TOP) ? '0 : cur_reg + SLOT_W'(1);
                        scan_idx_next = '0;
                        hit_mask_next = '0;
                        hit_cnt_next  = '0;
                        state_next    = ST_SCAN;
                    end else begin
                        id_next    = id_idx;
                        zero_next  = (s_timeout == '0);
                        state_next = ST_RESP;
                        if (id_ok) begin
                            if (s_op == OP_ADD
                                || (s_op == OP_REFRESH && armed_reg[id_idx])) begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end else if (s_op == OP_REMOVE && armed_reg[id_idx]) begin
                                armed_next[id_idx] = 1'b0;
                                total_next         = total_reg - CNT_W'(1);
                            end
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_ARM;
                end
            end
            ST_ARM: begin
                if (!armed_reg[id_reg]) begin
                    total_next = total_reg + CNT_W'(1);
                end
                armed_next[id_reg] = 1'b1;
                state_next         = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_exp_next   = 1'b0;
                    m_id_next    = '0;
                    m_last_next  = 1'b1;
                    m_live_next  = 7'(total_reg);
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // Issue one read a cycle; compare the entry read the cycle before.
                if (mem_re) begin
                    cmp_vld_next  = 1'b1;
                    cmp_id_next   = scan_idx_reg[ID_W-1:0];
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                if (scan_hit) begin
                    armed_next[cmp_id_reg]   = 1'b0;
                    hit_mask_next[cmp_id_reg] = 1'b1;
                    total_next               = total_reg - CNT_W'(1);
                    hit_cnt_next             = hit_cnt_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && cmp_id_reg == ID_TOP) begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (hit_cnt_reg == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_exp_next   = 1'b0;
                        m_id_next    = '0;
                        m_last_next  = 1'b1;
                        m_live_next  = 7'(total_reg);
                        state_next   = ST_IDLE;
                    end
                end else if (!hit_mask_reg[emit_idx_reg]) begin
                    emit_idx_next = emit_idx_reg + ID_W'(1);
                end else if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_exp_next    = 1'b1;
                    m_id_next     = 6'(emit_idx_reg);
                    m_last_next   = (hit_cnt_reg == CNT_W'(1));
                    m_live_next   = 7'(total_reg);
                    hit_cnt_next  = hit_cnt_reg - CNT_W'(1);
                    emit_idx_next = emit_idx_reg + ID_W'(1);
                    if (hit_cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tick_ms_reg <= TICK_MS_RESET;
            cur_reg     <= '0;
            armed_reg   <= '0;
            total_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            hit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_ms_reg <= tick_ms_next;
            cur_reg     <= cur_next;
            armed_reg   <= armed_next;
            total_reg   <= total_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_cnt_reg <= hit_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        id_reg       <= id_next;
        zero_reg     <= zero_next;
        scan_idx_reg <= scan_idx_next;
        cmp_id_reg   <= cmp_id_next;
        hit_mask_reg <= hit_mask_next;
        emit_idx_reg <= emit_idx_next;
        m_exp_reg    <= m_exp_next;
        m_id_reg     <= m_id_next;
        m_last_reg   <= m_last_next;
        m_live_reg   <= m_live_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[id_reg] <= target;
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[scan_idx_reg[ID_W-1:0]];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_live_reg, m_id_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_exp_reg;

endmodule

FILE: rtl/htw_checker.sv
// Port-level checks of the hashed timer wheel, bound to the top level.
module htw_checker
    import htw_pkg::*;
#(
    parameter int unsigned MAX_IDS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tlast,
    input  logic [0:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready
);

    // Each accepted transaction takes the sequencer out of idle, so s_tready drops after an accept.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A result without an expiry is always the single, final one.
    a_plain_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[5:0] == 6'd0))
        else $error("non-expiry result not last or carries an id");

    // Live count never exceeds the id space.
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:6] <= 7'(MAX_IDS)))
        else $error("live count out of range");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind hashed_timer_wheel htw_checker #(.MAX_IDS(MAX_IDS)) u_htw_checker (.*);

FILE: tb/hashed_timer_wheel_checker.sv
// Checker for the hashed timer wheel: watches the channels, predicts results and compares.
`timescale 1ns / 100ps
module hashed_timer_wheel_checker
    import htw_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 256,
    parameter int unsigned MAX_IDS   = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           s_tdata,   // [5:0] conn_id, [37:6] timeout, [39:38] zero
    input  logic [1:0]            s_tuser,   // [1:0] operation

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,   // [5:0] expired_id, [12:6] live_count, [15:13] zero
    input  logic                  m_tlast,
    input  logic [0:0]            m_tuser,   // [0] expired_valid

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,

    output int                    pending,
    output int                    failures
);

    localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);

    typedef struct packed {
        logic       fired;
        logic [5:0] id;
        logic       last;
        logic [6:0] live;
    } expiry_t;

    expiry_t            expiry_q[$];
    logic [TICK_W-1:0]  tick_len;
    logic [SLOT_W-1:0]  now_slot;
    logic [MAX_IDS-1:0] armed;
    logic [SLOT_W-1:0]  slot_of[MAX_IDS];
    logic [6:0]         live;
    int                 mismatches = 0;

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Slot a timer lands in: ceiling of delay over tick length, at least one tick ahead.
    function automatic logic [SLOT_W-1:0] target_of(logic [31:0] ms);
        logic [63:0] len;
        logic [63:0] ticks;
        len   = (tick_len == '0) ? 64'd1 : 64'(tick_len);
        ticks = (64'(ms) + len - 64'd1) / len;
        if (ticks == 64'd0)
            ticks = 64'd1;
        return SLOT_W'((64'(now_slot) + ticks) % NUM_SLOTS);
    endfunction

    task automatic drop_timer(int id);
        if (armed[id]) begin
            armed[id] = 1'b0;
            live      = live - 7'd1;
        end
    endtask

    task automatic predict(op_t op, logic [5:0] id, logic [31:0] ms);
        expiry_t e;
        int      hits[$];
        if (op == OP_TICK) begin
            now_slot = SLOT_W'((64'(now_slot) + 64'd1) % NUM_SLOTS);
            for (int i = 0; i < MAX_IDS; i++) begin
                if (armed[i] && slot_of[i] == now_slot) begin
                    hits = {hits, i};
                    drop_timer(i);
                end
            end
        end else if (id < MAX_IDS) begin
            if (op == OP_ADD || (op == OP_REFRESH && armed[id])) begin
                drop_timer(id);
                slot_of[id] = target_of(ms);
                armed[id]   = 1'b1;
                live        = live + 7'd1;
            end else if (op == OP_REMOVE) begin
                drop_timer(id);
            end
        end
        // live count is the one after the whole operation, on every transaction
        if (hits.size() == 0) begin
            e = '{1'b0, 6'd0, 1'b1, live};
            expiry_q = {expiry_q, e};
        end
        foreach (hits[k]) begin
            e = '{1'b1, 6'(hits[k]), (k == hits.size() - 1), live};
            expiry_q = {expiry_q, e};
        end
    endtask

    task automatic check_result(expiry_t got);
        expiry_t want;
        if (expiry_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result valid=%0d id=%0d last=%0d live=%0d",
                got.fired, got.id, got.last, got.live));
        end else begin
            want = expiry_q.pop_front();
            if (got !== want)
                flag_mismatch($sformatf({"result mismatch: expected valid=%0d id=%0d last=%0d ",
                    "live=%0d, got valid=%0d id=%0d last=%0d live=%0d"},
                    want.fired, want.id, want.last, want.live,
                    got.fired, got.id, got.last, got.live));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tick_len = TICK_MS_RESET;
            now_slot = '0;
            armed    = '0;
            live     = '0;
            expiry_q.delete();
        end else begin
            if (psel && penable && pready && paddr[2] == REG_TICK_MS) begin
                if (pwrite)
                    tick_len = pwdata[TICK_W-1:0];
                else if (prdata[TICK_W-1:0] !== tick_len)
                    flag_mismatch($sformatf("tick_ms read mismatch: expected %0d, got %0d",
                        tick_len, prdata[TICK_W-1:0]));
            end
            if (s_tvalid && s_tready)
                predict(op_t'(s_tuser), s_tdata[5:0], s_tdata[37:6]);
            if (m_tvalid && m_tready)
                check_result({m_tuser[0], m_tdata[5:0], m_tlast, m_tdata[12:6]});
        end
        pending  <= expiry_q.size();
        failures <= mismatches;
    end

endmodule

FILE: tb/hashed_timer_wheel_test.sv
// Testbench top for the hashed timer wheel: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module hashed_timer_wheel_test;
    import htw_pkg::*;

    localparam int unsigned WHEEL_SLOTS = 256;
    localparam int unsigned MAX_IDS     = 64;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          DRAIN_WAIT  = 200;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata  = '0;   // [5:0] conn_id, [37:6] timeout, [39:38] zero
    logic [1:0]            s_tuser  = '0;   // [1:0] operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // [5:0] expired_id, [12:6] live_count, [15:13] zero
    logic                  m_tlast;
    logic [0:0]            m_tuser;         // [0] expired_valid
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int          pending;
    int          failures;
    int          idle_cycles  = 0;
    int          stall_left   = 0;
    bit          steady       = 1'b0;
    int unsigned tick_setting = TICK_MS_RESET;

    hashed_timer_wheel #(
        .NUM_SLOTS (WHEEL_SLOTS),
        .MAX_IDS   (MAX_IDS)
    ) dut (.*);

    hashed_timer_wheel_checker #(
        .NUM_SLOTS (WHEEL_SLOTS),
        .MAX_IDS   (MAX_IDS)
    ) expiry_check (.*);

    always #10 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
                stall_left <= gap_len();
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("hashed_timer_wheel test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(op_t op, logic [5:0] id, logic [31:0] ms);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, ms, id};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic apb_access(logic write, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {REG_TICK_MS, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_tick(int unsigned ms);
        tick_setting = (ms == 0) ? 1 : ms;
        apb_access(1'b1, ms);
        apb_access(1'b0, 32'd0);
    endtask

    // Wait until every transaction sent so far has produced all its results.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Mostly delays of a few ticks so timers expire while the run lasts.
    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'd0;
            2:       return tick_setting * WHEEL_SLOTS * $urandom_range(1, 2);
            default: return tick_setting * $urandom_range(0, 4) + $urandom_range(0, tick_setting - 1);
        endcase
    endfunction

    task automatic random_ops(int count, int tick_pct);
        int         r;
        logic [5:0] id;
        op_t        op;
        for (int n = 0; n < count; n++) begin
            r  = $urandom_range(0, 99);
            id = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 11))
                                             : 6'($urandom_range(0, MAX_IDS - 1));
            if (r < tick_pct)
                op = OP_TICK;
            else if (r < tick_pct + (100 - tick_pct) / 2)
                op = OP_ADD;
            else if (r < tick_pct + (100 - tick_pct) * 3 / 4)
                op = OP_REFRESH;
            else
                op = OP_REMOVE;
            send_op(op, id, pick_delay());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        apb_access(1'b0, 32'd0);

        // tick length 10 from reset
        send_op(OP_TICK, 6'd0, 32'd0);
        send_op(OP_ADD, 6'd0, 32'd0);
        send_op(OP_ADD, 6'd63, 32'hFFFF_FFFF);
        send_op(OP_ADD, 6'd3, 32'd10);
        send_op(OP_ADD, 6'd1, 32'd9);
        send_op(OP_ADD, 6'd2, 32'd11);
        send_op(OP_ADD, 6'd2, 32'd1);
        send_op(OP_REFRESH, 6'd7, 32'd5);
        send_op(OP_REMOVE, 6'd8, 32'd0);
        send_op(OP_REFRESH, 6'd1, 32'd2560);
        send_op(OP_REMOVE, 6'd63, 32'd0);
        send_op(OP_TICK, 6'd63, 32'hFFFF_FFFF);
        send_op(OP_TICK, 6'd0, 32'd0);
        send_op(OP_ADD, 6'd42, 32'd0);
        send_op(OP_REFRESH, 6'd42, 32'd20);
        send_op(OP_TICK, 6'd0, 32'd0);
        send_op(OP_TICK, 6'd0, 32'd0);
        drain();

        // every id in one slot, added in descending order
        steady = 1'b1;
        set_tick(1);
        for (int i = MAX_IDS - 1; i >= 0; i--)
            send_op(OP_ADD, 6'(i), 32'd0);
        send_op(OP_TICK, 6'd0, 32'd0);
        send_op(OP_ADD, 6'(MAX_IDS - 1), 32'(WHEEL_SLOTS));
        random_ops(30, 40);
        drain();

        steady = 1'b0;
        set_tick(32'h0000_FFFF);
        random_ops(40, 35);
        drain();

        set_tick(0);
        random_ops(40, 40);
        drain();

        steady = 1'b1;
        set_tick($urandom_range(2, 200));
        random_ops(20, 45);
        steady = 1'b0;
        random_ops(20, 45);
        drain();

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (failures == 0)
            $display("hashed_timer_wheel test passed");
        else
            $display("hashed_timer_wheel test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/htw_pkg.sv
rtl/htw_div.sv
rtl/hashed_timer_wheel.sv
rtl/htw_checker.sv
tb/hashed_timer_wheel_checker.sv
tb/hashed_timer_wheel_test.sv
